// ----- hdl/mcrs_pkg.sv -----
// Shared constants and codes for the multi-channel RSSI smoother.
package mcrs_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int WINDOW_DEF   = 8;

    localparam int CH_FIELD_W = 3;
    localparam int RSSI_W     = 8;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FILLER_RSSI   = CFG_IDX_W'(1);

    localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RST = 16'd3000;
    localparam logic signed [RSSI_W-1:0] FILLER_RST  = -8'sd99;

endpackage

// ----- hdl/mcrs_in_if.sv -----
// Input stream interface: sample or tick word with valid/ready.
interface mcrs_in_if import mcrs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [CH_FIELD_W-1:0]    channel;
    logic signed [RSSI_W-1:0] rssi;
    logic [TIME_W-1:0]        now_ms;

    modport source (output valid, func, channel, rssi, now_ms, input ready);
    modport sink   (input valid, func, channel, rssi, now_ms, output ready);
endinterface

// ----- hdl/mcrs_out_if.sv -----
// Result stream interface: channel average word with valid/ready.
interface mcrs_out_if import mcrs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CH_FIELD_W-1:0]    out_channel;
    logic signed [RSSI_W-1:0] average;
    logic                     last;

    modport source (output valid, out_channel, average, last, input ready);
    modport sink   (input valid, out_channel, average, last, output ready);
endinterface

// ----- hdl/multi_channel_rssi_smoother_core.sv -----
// Multi-channel RSSI smoother: per-channel moving average with staleness filler.
//
// Input words arrive on i_in: func selects a sample (one result, last set) or a
// tick, which fills every stale channel with the filler value in ascending
// order and gives one result per stale channel, last on the final one. A
// sample for a channel at or above CHANNELS, or a tick with nothing stale,
// gives no result. Configuration is written through i_cfg_we/idx/data; the user
// must write it only while the block is idle, which the block does not enforce.
// Each push takes a write step, a sample RAM read and then an accumulate for
// each valid window entry, SUM_W restoring-division steps and an output step;
// the next word is taken only once the block is back in idle. A tick passes
// through a check state for every channel up to the last stale one, on top of
// a push per stale channel.
// i_in.ready is high only between items; the result register lets a new
// word in while a result waits, but the next result stalls until o_out.ready.
// Reset clears the ring positions, full flags, last-seen times and the
// configuration; the sample RAM needs no clearing, as only written entries are
// summed.
module multi_channel_rssi_smoother_core import mcrs_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int WINDOW   = WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mcrs_in_if.sink               i_in,
    mcrs_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int ADDR_W = CH_W + POS_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int SUM_W  = RSSI_W + CNT_W;
    localparam int DIV_W  = $clog2(SUM_W + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_WRITE = 7'b0000100,
        S_RADDR = 7'b0001000,
        S_RACC  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                   r_state, n_state;
    logic [CH_W-1:0]          r_ch, n_ch;
    logic                     r_tick, n_tick;
    logic [CHANNELS-1:0]      r_mask, n_mask;
    logic [POS_W-1:0]         r_pos [CHANNELS];
    logic [POS_W-1:0]         n_pos [CHANNELS];
    logic [CHANNELS-1:0]      r_full, n_full;
    logic [TIME_W-1:0]        r_seen [CHANNELS];
    logic [TIME_W-1:0]        n_seen [CHANNELS];
    logic [TIMEOUT_W-1:0]     r_timeout;
    logic signed [RSSI_W-1:0] r_filler;
    logic                     r_ovalid, n_ovalid;

    logic signed [RSSI_W-1:0] r_val, n_val;
    logic [TIME_W-1:0]        r_now, n_now;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [POS_W-1:0]         r_idx, n_idx;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]         r_rem, n_rem;
    logic [SUM_W-1:0]         r_quo, n_quo;
    logic                     r_neg, n_neg;
    logic [DIV_W-1:0]         r_dstep, n_dstep;
    logic [CH_FIELD_W-1:0]    r_ochan, n_ochan;
    logic signed [RSSI_W-1:0] r_oavg, n_oavg;
    logic                     r_olast, n_olast;

    logic signed [RSSI_W-1:0] mem [DEPTH];
    logic signed [RSSI_W-1:0] r_rd;

    logic [CHANNELS-1:0] stale;
    logic                in_acc;
    logic                out_load;
    logic [POS_W-1:0]    cur_pos, nxt_pos;
    logic                nxt_full;
    logic [CNT_W:0]      div_shift, div_trial;
    logic [RSSI_W-1:0]   quo_lo;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            stale[c] = (i_in.now_ms - r_seen[c]) >= {16'b0, r_timeout};
        end
    end

    assign in_acc   = i_in.valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_out.ready);

    assign cur_pos  = r_pos[r_ch];
    assign nxt_pos  = (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + POS_W'(1);
    assign nxt_full = r_full[r_ch] || (nxt_pos == '0);

    assign div_shift = {r_rem, r_quo[SUM_W-1]};
    assign div_trial = div_shift - {1'b0, r_cnt};
    assign quo_lo    = r_quo[RSSI_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_tick   = r_tick;
        n_mask   = r_mask;
        n_pos    = r_pos;
        n_full   = r_full;
        n_seen   = r_seen;
        n_ovalid = r_ovalid;
        n_val    = r_val;
        n_now    = r_now;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_neg    = r_neg;
        n_dstep  = r_dstep;
        n_ochan  = r_ochan;
        n_oavg   = r_oavg;
        n_olast  = r_olast;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_now = i_in.now_ms;
                    if (i_in.func == FUNC_SAMPLE) begin
                        n_ch   = CH_W'(i_in.channel);
                        n_val  = i_in.rssi;
                        n_tick = 1'b0;
                        if (32'(i_in.channel) < 32'(CHANNELS)) begin
                            n_state = S_WRITE;
                        end
                    end else begin
                        n_ch   = '0;
                        n_tick = 1'b1;
                        n_mask = stale;
                        if (stale != '0) begin
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (r_mask[r_ch]) begin
                    n_val   = r_filler;
                    n_state = S_WRITE;
                end else begin
                    n_ch = r_ch + CH_W'(1);
                end
            end
            S_WRITE: begin
                n_pos[r_ch]  = nxt_pos;
                n_full[r_ch] = nxt_full;
                n_seen[r_ch] = r_now;
                n_cnt        = nxt_full ? CNT_W'(WINDOW) : CNT_W'(nxt_pos);
                n_idx        = '0;
                n_sum        = '0;
                n_state      = S_RADDR;
            end
            S_RADDR: begin
                n_state = S_RACC;
            end
            S_RACC: begin
                n_sum = r_sum + SUM_W'(r_rd);
                n_idx = r_idx + POS_W'(1);
                if (CNT_W'(r_idx) + CNT_W'(1) == r_cnt) begin
                    n_neg   = n_sum[SUM_W-1];
                    n_quo   = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
                    n_rem   = '0;
                    n_dstep = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_RADDR;
                end
            end
            S_DIV: begin
                if (!div_trial[CNT_W]) begin
                    n_rem = div_trial[CNT_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = div_shift[CNT_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end
                n_dstep = r_dstep + DIV_W'(1);
                if (r_dstep == DIV_W'(SUM_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_mask[r_ch] = 1'b0;
                    n_ovalid     = 1'b1;
                    n_ochan      = CH_FIELD_W'(r_ch);
                    n_oavg       = r_neg ? -$signed(quo_lo) : $signed(quo_lo);
                    n_olast      = !r_tick || (n_mask == '0);
                    if (r_tick && (n_mask != '0)) begin
                        n_ch    = r_ch + CH_W'(1);
                        n_state = S_CHECK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ch      <= '0;
            r_tick    <= 1'b0;
            r_mask    <= '0;
            r_full    <= '0;
            r_ovalid  <= 1'b0;
            r_timeout <= TIMEOUT_RST;
            r_filler  <= FILLER_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c]  <= '0;
                r_seen[c] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_tick   <= n_tick;
            r_mask   <= n_mask;
            r_pos    <= n_pos;
            r_full   <= n_full;
            r_seen   <= n_seen;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STALE_TIMEOUT: r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                    CFG_FILLER_RSSI:   r_filler  <= $signed(i_cfg_data[RSSI_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_now   <= n_now;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_sum   <= n_sum;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_neg   <= n_neg;
        r_dstep <= n_dstep;
        r_ochan <= n_ochan;
        r_oavg  <= n_oavg;
        r_olast <= n_olast;
    end

    // sample RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            mem[{r_ch, cur_pos}] <= r_val;
        end
        r_rd <= mem[{r_ch, r_idx}];
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.out_channel = r_ochan;
    assign o_out.average     = r_oavg;
    assign o_out.last        = r_olast;

`ifndef NO_ASSERTIONS
    a_check_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_mask != '0))
        else $error("channel walk with no stale channel left");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_cnt != '0) && (r_cnt <= CNT_W'(WINDOW))))
        else $error("divisor out of range");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out.valid)
        else $error("result word lost");

    a_quiet_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.func == FUNC_TICK) && (stale == '0)) |=> (r_state == S_IDLE))
        else $error("tick without stale channel left idle");
`endif

endmodule

// ----- verif/multi_channel_rssi_smoother_core_tb.sv -----
// Self-checking testbench for the multi-channel RSSI smoother core.
module multi_channel_rssi_smoother_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcrs_pkg::*;

    localparam int CHANNELS     = CHANNELS_DEF;
    localparam int WINDOW       = WINDOW_DEF;
    localparam int DRAIN_CYCLES = 600;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(15);

    typedef enum logic [1:0] {CHK_MODEL, CHK_GIVEN, CHK_SILENT} t_row_check;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]    ch;
        logic signed [RSSI_W-1:0] avg;
        logic                     last;
    } t_avg_word;

    typedef struct {
        t_row_check               kind;
        logic                     func;
        logic [CH_FIELD_W-1:0]    ch;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        now;
        logic signed [RSSI_W-1:0] avg;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mcrs_in_if  in_bus ();
    mcrs_out_if out_bus ();

    multi_channel_rssi_smoother_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted block state
    logic signed [RSSI_W-1:0] ring_mem [CHANNELS][WINDOW];
    int                       ring_pos [CHANNELS];
    bit                       ring_full [CHANNELS];
    logic [TIME_W-1:0]        seen_ms [CHANNELS];
    logic [TIMEOUT_W-1:0]     stale_limit;
    logic signed [RSSI_W-1:0] filler_val;

    t_avg_word         avg_q[$];
    int                fault_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic [TIME_W-1:0] clock_ms;
    t_stim_row         directed_rows [20];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [RSSI_W-1:0] push_avg(int ch, logic signed [RSSI_W-1:0] v,
                                                          logic [TIME_W-1:0] now);
        int count;
        int total = 0;
        ring_mem[ch][ring_pos[ch]] = v;
        ring_pos[ch] = (ring_pos[ch] + 1) % WINDOW;
        if (ring_pos[ch] == 0) begin
            ring_full[ch] = 1'b1;
        end
        count = ring_full[ch] ? WINDOW : ring_pos[ch];
        for (int i = 0; i < count; i++) begin
            total += int'(ring_mem[ch][i]);
        end
        seen_ms[ch] = now;
        return RSSI_W'(total / count);
    endfunction

    function automatic void predict_word(logic func, logic [CH_FIELD_W-1:0] ch,
                                         logic signed [RSSI_W-1:0] rssi,
                                         logic [TIME_W-1:0] now, bit enqueue);
        logic signed [RSSI_W-1:0] avg;
        logic [CHANNELS-1:0]      stale = '0;
        int                       top = -1;
        if (func == FUNC_SAMPLE) begin
            if (int'(ch) < CHANNELS) begin
                avg = push_avg(int'(ch), rssi, now);
                if (enqueue) avg_q.push_back('{ch, avg, 1'b1});
            end
        end else begin
            // staleness is per channel, so it can be settled before any filler goes in
            for (int c = 0; c < CHANNELS; c++) begin
                if (now - seen_ms[c] >= TIME_W'(stale_limit)) begin
                    stale[c] = 1'b1;
                    top = c;
                end
            end
            for (int c = 0; c < CHANNELS; c++) begin
                if (stale[c]) begin
                    avg = push_avg(c, filler_val, now);
                    if (enqueue) avg_q.push_back('{CH_FIELD_W'(c), avg, 1'(c == top)});
                end
            end
        end
    endfunction

    task automatic apply_config(logic [TIMEOUT_W-1:0] limit, logic [CFG_DATA_W-1:0] filler_word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_STALE_TIMEOUT;
        i_cfg_data <= CFG_DATA_W'(limit);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FILLER_RSSI;
        i_cfg_data <= filler_word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        stale_limit = limit;
        filler_val  = filler_word[RSSI_W-1:0];
    endtask

    task automatic wait_idle();
        while (avg_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_word(t_row_check kind, logic func, logic [CH_FIELD_W-1:0] ch,
                             logic signed [RSSI_W-1:0] rssi, logic [TIME_W-1:0] now,
                             logic signed [RSSI_W-1:0] given_avg);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.func    <= func;
        in_bus.channel <= ch;
        in_bus.rssi    <= rssi;
        in_bus.now_ms  <= now;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        case (kind)
            CHK_MODEL: begin
                predict_word(func, ch, rssi, now, 1'b1);
            end
            CHK_GIVEN: begin
                predict_word(func, ch, rssi, now, 1'b0);
                avg_q.push_back('{ch, given_avg, 1'b1});
            end
            default: begin
                predict_word(func, ch, rssi, now, 1'b0);
            end
        endcase
    endtask

    task automatic send_random();
        int   r;
        logic func;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            clock_ms = $urandom;
        end else if (r < 20) begin
            clock_ms += $urandom_range(0, 2 * int'(stale_limit) + 10);
        end else begin
            clock_ms += $urandom_range(0, int'(stale_limit) / 8 + 20);
        end
        func = ($urandom_range(0, 99) < 25) ? FUNC_TICK : FUNC_SAMPLE;
        send_word(CHK_MODEL, func, CH_FIELD_W'($urandom), RSSI_W'($urandom), clock_ms, '0);
    endtask

    always @(posedge i_clk) begin : result_check
        t_avg_word want;
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (avg_q.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS) begin
                    $display("unexpected word: ch %0d avg %0d last %0b",
                             out_bus.out_channel, out_bus.average, out_bus.last);
                end
            end else begin
                want = avg_q.pop_front();
                if (out_bus.out_channel !== want.ch || out_bus.average !== want.avg ||
                    out_bus.last !== want.last) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("mismatch: want %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.ch, want.avg, want.last,
                                 out_bus.out_channel, out_bus.average, out_bus.last);
                    end
                end
            end
        end
    end

    initial begin
        int n_items;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_STALE_TIMEOUT;
        i_cfg_data     <= '0;
        in_bus.valid   <= 1'b0;
        in_bus.func    <= FUNC_SAMPLE;
        in_bus.channel <= '0;
        in_bus.rssi    <= '0;
        in_bus.now_ms  <= '0;
        for (int c = 0; c < CHANNELS; c++) begin
            ring_pos[c]  = 0;
            ring_full[c] = 1'b0;
            seen_ms[c]   = '0;
        end
        stale_limit = TIMEOUT_RST;
        filler_val  = FILLER_RST;

        directed_rows = '{
            '{CHK_SILENT, FUNC_TICK,   3'd0, 8'sd0,    32'd2999,      8'sd0},
            '{CHK_GIVEN,  FUNC_SAMPLE, 3'd0, 8'sd127,  32'd100,       8'sd127},
            '{CHK_GIVEN,  FUNC_SAMPLE, 3'd0, -8'sd128, 32'd101,       8'sd0},
            '{CHK_GIVEN,  FUNC_SAMPLE, 3'd0, -8'sd128, 32'd102,       -8'sd43},
            '{CHK_GIVEN,  FUNC_SAMPLE, 3'd1, -8'sd128, 32'd200,       -8'sd128},
            '{CHK_GIVEN,  FUNC_SAMPLE, 3'd7, 8'sd127,  32'hFFFF_FFFF, 8'sd127},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd2, 8'sd127,  32'd300,       8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd2, -8'sd128, 32'd301,       8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd2, 8'sd127,  32'd302,       8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd2, -8'sd128, 32'd303,       8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd2, 8'sd127,  32'd304,       8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd2, -8'sd128, 32'd305,       8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd2, 8'sd127,  32'd306,       8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd2, -8'sd128, 32'd307,       8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd2, -8'sd128, 32'd308,       8'sd0},
            '{CHK_MODEL,  FUNC_TICK,   3'd5, 8'sd55,   32'd3000,      8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd3, 8'sd127,  32'd0,         8'sd0},
            '{CHK_MODEL,  FUNC_TICK,   3'd7, -8'sd1,   32'd2999,      8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd6, -8'sd1,   32'h5555_5555, 8'sd0},
            '{CHK_MODEL,  FUNC_SAMPLE, 3'd5, 8'sd1,    32'hAAAA_AAAA, 8'sd0}
        };

        send_idle_pct = 17;
        recv_idle_pct = 87;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // write to an unmapped index, defaults must survive
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_UNMAPPED;
        i_cfg_data <= '1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].kind, directed_rows[i].func, directed_rows[i].ch,
                      directed_rows[i].rssi, directed_rows[i].now, directed_rows[i].avg);
        end
        in_bus.valid <= 1'b0;
        wait_idle();

        clock_ms = 32'h0000_1000;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    apply_config(16'd0, 16'hFF7F);
                    n_items = 60;
                end
                1: begin
                    send_idle_pct = 87;
                    recv_idle_pct = 17;
                    apply_config(16'hFFFF, 16'h0080);
                    n_items = 100;
                end
                2: begin
                    apply_config(TIMEOUT_W'($urandom_range(1, 5000)), CFG_DATA_W'($urandom));
                    n_items = 100;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    apply_config(16'd500, CFG_DATA_W'($urandom));
                    n_items = 90;
                end
            endcase
            repeat (n_items) send_random();
            in_bus.valid <= 1'b0;
            wait_idle();
        end

        if (fault_count == 0 && avg_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mcrs_pkg.sv
hdl/mcrs_in_if.sv
hdl/mcrs_out_if.sv
hdl/multi_channel_rssi_smoother_core.sv
verif/multi_channel_rssi_smoother_core_tb.sv
